@@ rtl/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and constants shared by the framed packet receiver files.
// ----------------------------------------------------------------------------
package fpr_pkg;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_END     = 3'd6,
    PH_LOCKED  = 3'd7
  } phase_e;

  localparam logic [2:0] REG_START_MARKER    = 3'd0;
  localparam logic [2:0] REG_END_MARKER      = 3'd1;
  localparam logic [2:0] REG_ACK_CODE        = 3'd2;
  localparam logic [2:0] REG_NACK_CODE       = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT     = 3'd4;
  localparam logic [2:0] REG_START_TYPE_CODE = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int unsigned FAULT_END  = 0;
  localparam int unsigned FAULT_XOR  = 1;
  localparam int unsigned FAULT_LINE = 2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_value;
    logic [15:0] payload_position;
    logic [7:0]  frame_kind;
    logic [15:0] frame_length;
    logic        frame_good;
    logic [2:0]  fault_bits;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        gave_up;
  } out_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [7:0] retry_limit;
    logic [7:0] start_type_code;
  } cfg_t;

endpackage

@@ rtl/framed_packet_receiver_xor_ack.sv @@
// Results are registered in the output register, or the skid stage on a stall.
// Throughput: one byte per cycle; the output register plus a one-entry skid
// stage let input continue while a result waits. Input stalls only while the
// skid stage is full. Reset (async, active low) returns to hunting, clears all
// counters and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
// framed_packet_receiver_xor_ack
// Deframes SOF/type/length/payload/XOR/EOF frames and issues ACK/NACK verdicts.
// ----------------------------------------------------------------------------
module framed_packet_receiver_xor_ack (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fpr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fpr_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);
  import fpr_pkg::*;

  cfg_t cfg_q;
  logic in_xfer;
  logic res_valid;
  out_t res;
  logic out_valid_q;
  out_t out_q;
  logic skid_valid_q;
  out_t skid_q;
  logic out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= 8'd170;
      cfg_q.end_marker      <= 8'd187;
      cfg_q.ack_code        <= 8'd0;
      cfg_q.nack_code       <= 8'd1;
      cfg_q.retry_limit     <= 8'd3;
      cfg_q.start_type_code <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_MARKER:    cfg_q.start_marker    <= cfg_data_i;
        REG_END_MARKER:      cfg_q.end_marker      <= cfg_data_i;
        REG_ACK_CODE:        cfg_q.ack_code        <= cfg_data_i;
        REG_NACK_CODE:       cfg_q.nack_code       <= cfg_data_i;
        REG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data_i;
        REG_START_TYPE_CODE: cfg_q.start_type_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;

  fpr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_xfer_i (in_xfer),
    .item_i      (in_data_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/fpr_core.sv @@
// ----------------------------------------------------------------------------
// fpr_core
// Frame parser: phase machine, length/XOR/error tracking and verdict logic.
// ----------------------------------------------------------------------------
module fpr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_xfer_i,
  input  fpr_pkg::in_t  item_i,
  input  fpr_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output fpr_pkg::out_t res_o
);
  import fpr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] taken_q, taken_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  chk_q, chk_d;
  logic        err_q, err_d;
  logic [7:0]  fail_q, fail_d;

  logic [7:0]  b;
  logic [15:0] taken_inc;
  logic [15:0] len_full;
  logic [2:0]  faults;
  logic [7:0]  fail_inc;
  logic        lock_now;

  assign b         = item_i.rx_byte;
  assign taken_inc = taken_q + 16'd1;
  assign len_full  = {b, len_q[7:0]};

  always_comb begin
    faults             = '0;
    faults[FAULT_END]  = (b != cfg_i.end_marker);
    faults[FAULT_XOR]  = (xor_q != chk_q);
    faults[FAULT_LINE] = err_q | item_i.rx_error;
  end

  assign fail_inc = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
  assign lock_now = (faults != '0) && (fail_inc > cfg_i.retry_limit);

  // next state
  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    taken_d = taken_q;
    xor_d   = xor_q;
    chk_d   = chk_q;
    err_d   = err_q;
    fail_d  = fail_q;
    if (item_xfer_i && phase_q != PH_LOCKED) begin
      err_d = err_q | item_i.rx_error;
      case (phase_q)
        PH_HUNT: begin
          if (b == cfg_i.start_marker) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          type_d  = b;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {8'd0, b};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = len_full;
          taken_d = '0;
          xor_d   = '0;
          phase_d = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          xor_d   = xor_q ^ b;
          taken_d = taken_inc;
          if (taken_inc == len_q) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          chk_d   = b;
          phase_d = PH_END;
        end
        PH_END: begin
          taken_d = '0;
          xor_d   = '0;
          err_d   = 1'b0;
          if (faults != '0) fail_d = fail_inc;
          phase_d = lock_now ? PH_LOCKED : PH_HUNT;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o        = 1'b0;
    res_o              = '0;
    res_o.frame_kind   = type_q;
    res_o.frame_length = len_q;
    case (phase_q)
      PH_PAYLOAD: begin
        res_valid_o            = item_xfer_i;
        res_o.item_kind        = KIND_PAYLOAD;
        res_o.payload_value    = b;
        res_o.payload_position = taken_q;
      end
      PH_END: begin
        res_valid_o     = item_xfer_i;
        res_o.item_kind = KIND_VERDICT;
        if (faults == '0) begin
          res_o.frame_good = 1'b1;
          if (type_q != cfg_i.start_type_code) begin
            res_o.reply_valid = 1'b1;
            res_o.reply_byte  = cfg_i.ack_code;
          end
        end else begin
          res_o.fault_bits  = faults;
          res_o.reply_valid = 1'b1;
          res_o.reply_byte  = cfg_i.nack_code;
          res_o.gave_up     = lock_now;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      type_q  <= '0;
      len_q   <= '0;
      taken_q <= '0;
      xor_q   <= '0;
      chk_q   <= '0;
      err_q   <= 1'b0;
      fail_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      taken_q <= taken_d;
      xor_q   <= xor_d;
      chk_q   <= chk_d;
      err_q   <= err_d;
      fail_q  <= fail_d;
    end
  end

endmodule

@@ rtl/fpr_checker.sv @@
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks for the framed packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fpr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fpr_pkg::out_t out_data_o
);
  import fpr_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == KIND_PAYLOAD |->
      !out_data_o.reply_valid && !out_data_o.frame_good &&
      out_data_o.fault_bits == '0 && !out_data_o.gave_up)
    else $error("payload transfer carries verdict fields");

  a_good_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == KIND_VERDICT && out_data_o.frame_good |->
      out_data_o.fault_bits == '0 && !out_data_o.gave_up)
    else $error("good verdict with faults or lock");

  a_bad_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == KIND_VERDICT && !out_data_o.frame_good |->
      out_data_o.reply_valid && out_data_o.fault_bits != '0)
    else $error("bad verdict without NACK or fault bits");

  a_locked_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_data_o.gave_up |=> !out_valid_o)
    else $error("result after lock");

endmodule

bind framed_packet_receiver_xor_ack fpr_checker u_fpr_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the framed packet receiver with XOR check and ACK.
// Feeds received bytes through the stall handshake: first a directed table,
// then random frames with random idles, line errors and corrupted check or
// end bytes. Several register settings are used, and the last one locks the
// receiver. A local deframer predicts the transfers of random frames, the
// table its own; each output transfer is compared by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import fpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam out_t NO_RESULT = '0;

  typedef enum logic [1:0] {
    SHAPE_ANY,
    SHAPE_CLEAN,
    SHAPE_BAD
  } shape_e;

  typedef struct packed {
    in_t  rx;
    logic typed;
    out_t want;
  } drow_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // deframer state and register copy
  cfg_t        regs = '{8'd170, 8'd187, 8'd0, 8'd1, 8'd3, 8'd0};
  phase_e      st_phase = PH_HUNT;
  logic [7:0]  cur_type = '0;
  logic [15:0] decl_len = '0;
  logic [15:0] taken = '0;
  logic [7:0]  run_xor = '0;
  logic [7:0]  chk_byte = '0;
  logic        err_seen = 1'b0;
  logic [7:0]  fail_cnt = '0;

  out_t        frame_results_q[$];
  int unsigned bytes_fed = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  bit          feed_calm = 1'b0;

  drow_t dtab [21] = '{
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hAA, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h5A, 1'b0}, 1'b1,
      '{KIND_PAYLOAD, 8'h5A, 16'h0000, 8'h00, 16'h0001, 1'b0, 3'b000, 1'b0, 8'h00, 1'b0}},
    '{'{8'h5A, 1'b0}, 1'b0, NO_RESULT},
    // start type: good, no reply
    '{'{8'hBB, 1'b0}, 1'b1,
      '{KIND_VERDICT, 8'h00, 16'h0000, 8'h00, 16'h0001, 1'b1, 3'b000, 1'b0, 8'h00, 1'b0}},
    '{'{8'hAA, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h7F, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    // empty payload, check 0: ACK
    '{'{8'hBB, 1'b0}, 1'b1,
      '{KIND_VERDICT, 8'h00, 16'h0000, 8'h7F, 16'h0000, 1'b1, 3'b000, 1'b1, 8'h00, 1'b0}},
    // line error while hunting
    '{'{8'hFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{8'hAA, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b1,
      '{KIND_VERDICT, 8'h00, 16'h0000, 8'hFF, 16'h0000, 1'b0, 3'b111, 1'b1, 8'h01, 1'b0}}
  };

  framed_packet_receiver_xor_ack dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit deframe_step(input in_t x, output out_t res);
    logic [2:0] faults;
    bit         lock;
    res = '0;
    faults = '0;
    lock = 1'b0;
    if (st_phase == PH_LOCKED) return 1'b0;
    if (x.rx_error) err_seen = 1'b1;
    case (st_phase)
      PH_HUNT: begin
        if (x.rx_byte == regs.start_marker) st_phase = PH_TYPE;
        return 1'b0;
      end
      PH_TYPE: begin
        cur_type = x.rx_byte;
        st_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        decl_len = {8'h00, x.rx_byte};
        st_phase = PH_LEN_HI;
        return 1'b0;
      end
      PH_LEN_HI: begin
        decl_len = {x.rx_byte, decl_len[7:0]};
        taken = '0;
        run_xor = '0;
        st_phase = (decl_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        res.item_kind = KIND_PAYLOAD;
        res.payload_value = x.rx_byte;
        res.payload_position = taken;
        res.frame_kind = cur_type;
        res.frame_length = decl_len;
        run_xor = run_xor ^ x.rx_byte;
        taken = taken + 16'd1;
        if (taken == decl_len) st_phase = PH_CHECK;
        return 1'b1;
      end
      PH_CHECK: begin
        chk_byte = x.rx_byte;
        st_phase = PH_END;
        return 1'b0;
      end
      default: begin
        faults[FAULT_END] = (x.rx_byte != regs.end_marker);
        faults[FAULT_XOR] = (run_xor != chk_byte);
        faults[FAULT_LINE] = err_seen;
        res.item_kind = KIND_VERDICT;
        res.frame_kind = cur_type;
        res.frame_length = decl_len;
        if (faults == 3'b000) begin
          res.frame_good = 1'b1;
          if (cur_type != regs.start_type_code) begin
            res.reply_valid = 1'b1;
            res.reply_byte = regs.ack_code;
          end
        end else begin
          res.fault_bits = faults;
          res.reply_valid = 1'b1;
          res.reply_byte = regs.nack_code;
          if (fail_cnt != 8'hFF) fail_cnt = fail_cnt + 8'd1;
          lock = (fail_cnt > regs.retry_limit);
        end
        st_phase = PH_HUNT;
        taken = '0;
        run_xor = '0;
        err_seen = 1'b0;
        if (lock) begin
          st_phase = PH_LOCKED;
          res.gave_up = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic e,
                           input bit typed = 1'b0, input out_t want = '0);
    int unsigned gap;
    out_t        res;
    bit          live;
    bit          got;
    gap = pick_gap(feed_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{rx_byte: b, rx_error: e};
    do @(posedge clk); while (in_stall);
    live = (st_phase != PH_LOCKED);
    got = deframe_step('{rx_byte: b, rx_error: e}, res);
    if (typed) frame_results_q.push_back(want);
    else if (got) frame_results_q.push_back(res);
    if (live) bytes_fed++;
    @(negedge clk);
  endtask

  function automatic logic line_err(input shape_e shape);
    return (shape == SHAPE_ANY) && ($urandom_range(0, 59) == 0);
  endfunction

  task automatic send_frame(input shape_e shape);
    int unsigned noise, len, r, k;
    logic [7:0]  b, kind, sum, chk, tail;
    feed_calm = ($urandom_range(0, 4) == 0);
    noise = $urandom_range(0, 3);
    repeat (noise) begin
      do b = 8'($urandom); while (b == regs.start_marker);
      send_byte(b, line_err(shape));
    end
    kind = ($urandom_range(0, 3) == 0) ? regs.start_type_code : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 95) len = $urandom_range(1, 12);
    else if (r < 98) len = $urandom_range(13, 255);
    else len = $urandom_range(256, 300);
    send_byte(regs.start_marker, line_err(shape));
    send_byte(kind, line_err(shape));
    send_byte(len[7:0], line_err(shape));
    send_byte(len[15:8], line_err(shape));
    sum = '0;
    for (k = 0; k < len; k++) begin
      b = 8'($urandom);
      sum = sum ^ b;
      send_byte(b, line_err(shape));
    end
    chk = sum;
    tail = regs.end_marker;
    if (shape == SHAPE_ANY && $urandom_range(0, 99) < 8)
      chk = sum ^ 8'($urandom_range(1, 255));
    if (shape == SHAPE_BAD || (shape == SHAPE_ANY && $urandom_range(0, 99) < 8))
      tail = regs.end_marker ^ 8'($urandom_range(1, 255));
    send_byte(chk, line_err(shape));
    send_byte(tail, line_err(shape));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_MARKER:    regs.start_marker = val;
      REG_END_MARKER:      regs.end_marker = val;
      REG_ACK_CODE:        regs.ack_code = val;
      REG_NACK_CODE:       regs.nack_code = val;
      REG_RETRY_LIMIT:     regs.retry_limit = val;
      REG_START_TYPE_CODE: regs.start_type_code = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    settle();
    write_reg(REG_START_MARKER, c.start_marker);
    write_reg(REG_END_MARKER, c.end_marker);
    write_reg(REG_ACK_CODE, c.ack_code);
    write_reg(REG_NACK_CODE, c.nack_code);
    write_reg(REG_RETRY_LIMIT, c.retry_limit);
    write_reg(REG_START_TYPE_CODE, c.start_type_code);
    write_reg(REG_SPARE_A, 8'($urandom));
    write_reg(REG_SPARE_B, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_data.item_kind, 0);
      end else begin
        want = frame_results_q.pop_front();
        if (out_data.item_kind !== want.item_kind)
          report_mismatch("item_kind", out_data.item_kind, want.item_kind);
        if (out_data.payload_value !== want.payload_value)
          report_mismatch("payload_value", out_data.payload_value, want.payload_value);
        if (out_data.payload_position !== want.payload_position)
          report_mismatch("payload_position", out_data.payload_position,
                          want.payload_position);
        if (out_data.frame_kind !== want.frame_kind)
          report_mismatch("frame_kind", out_data.frame_kind, want.frame_kind);
        if (out_data.frame_length !== want.frame_length)
          report_mismatch("frame_length", out_data.frame_length, want.frame_length);
        if (out_data.frame_good !== want.frame_good)
          report_mismatch("frame_good", out_data.frame_good, want.frame_good);
        if (out_data.fault_bits !== want.fault_bits)
          report_mismatch("fault_bits", out_data.fault_bits, want.fault_bits);
        if (out_data.reply_valid !== want.reply_valid)
          report_mismatch("reply_valid", out_data.reply_valid, want.reply_valid);
        if (out_data.reply_byte !== want.reply_byte)
          report_mismatch("reply_byte", out_data.reply_byte, want.reply_byte);
        if (out_data.gave_up !== want.gave_up)
          report_mismatch("gave_up", out_data.gave_up, want.gave_up);
      end
      results_seen++;
    end
  end

  initial begin : sink_side
    int unsigned spell, n, long_holds;
    bit          calm;
    out_stall = 1'b0;
    spell = 0;
    long_holds = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      // long hold-off so the output side backs up into the input
      if (long_holds < 2 && results_seen >= (long_holds == 0 ? 40 : 300)) begin
        long_holds++;
        out_stall <= 1'b1;
        repeat (90) @(negedge clk);
      end
      if (spell == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        spell = $urandom_range(20, 150);
      end
      spell--;
      n = pick_gap(calm);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dtab[i]) send_byte(dtab[i].rx.rx_byte, dtab[i].rx.rx_error,
                                dtab[i].typed, dtab[i].want);

    load_regs('{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF});
    while (bytes_fed < 220) send_frame(SHAPE_ANY);
    load_regs('{8'hFF, 8'h00, 8'h00, 8'hFF, 8'd254, 8'h00});
    while (bytes_fed < 440) send_frame(SHAPE_ANY);
    load_regs('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF,
                8'($urandom)});
    while (bytes_fed < 650) send_frame(SHAPE_ANY);
    load_regs('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF,
                8'($urandom)});
    while (bytes_fed < 850) send_frame(SHAPE_ANY);

    // limit 0: a good frame passes, the next bad one locks the receiver
    load_regs('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00,
                8'($urandom)});
    send_frame(SHAPE_CLEAN);
    send_frame(SHAPE_BAD);
    send_frame(SHAPE_ANY);
    send_frame(SHAPE_CLEAN);

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fpr_pkg.sv
rtl/fpr_core.sv
rtl/framed_packet_receiver_xor_ack.sv
rtl/fpr_checker.sv
tb/sv/testbench.sv
